// ===== rtl/core/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared sizes, codes and interface structs for the class pattern search.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Sizes
  localparam int MAX_TOKENS = 16;
  localparam int POS_BITS   = 16;
  localparam int IDX_BITS   = $clog2(MAX_TOKENS);
  localparam int CNT_BITS   = $clog2(MAX_TOKENS + 1);
  localparam int START_BITS = 16;

  // Item operations
  localparam logic [1:0] OP_TOKEN   = 2'd0;
  localparam logic [1:0] OP_MEMBER  = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Token kinds
  localparam logic [2:0] KIND_LITERAL = 3'd0;
  localparam logic [2:0] KIND_ANY     = 3'd1;
  localparam logic [2:0] KIND_SET     = 3'd2;
  localparam logic [2:0] KIND_NSET    = 3'd3;
  localparam logic [2:0] KIND_LOWER   = 3'd4;
  localparam logic [2:0] KIND_UPPER   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_SET = 2'd2;

  // Letter bounds
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // Pattern store view handed to the search engine
  typedef struct packed {
    logic [MAX_TOKENS-1:0] hits;
    logic [CNT_BITS-1:0]   count;
  } pat_t;

  // Search result for one item
  typedef struct packed {
    logic                  found;
    logic [START_BITS-1:0] start;
    logic                  done;
  } res_t;

endpackage

// ===== rtl/core/cps_pattern.sv =====
// ----------------------------------------------------------------------------
// cps_pattern
// Token store with per-token byte sets; compares one byte against all tokens.
// ----------------------------------------------------------------------------
module cps_pattern (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            op,
  input  logic [2:0]            token_kind,
  input  logic [7:0]            byte_value,
  output cps_pkg::pat_t         pat,
  output logic [1:0]            status
);

  logic [2:0]                   kind_q  [cps_pkg::MAX_TOKENS];
  logic [7:0]                   byte_q  [cps_pkg::MAX_TOKENS];
  logic [255:0]                 set_map [cps_pkg::MAX_TOKENS];
  logic [cps_pkg::CNT_BITS-1:0] token_count;
  logic [cps_pkg::IDX_BITS-1:0] last_idx;
  logic                         full;
  logic                         last_is_set;
  logic                         do_append;
  logic                         do_member;

  // Load checks against the most recent token
  always_comb begin
    last_idx    = cps_pkg::IDX_BITS'(token_count - 1'b1);
    full        = (token_count == cps_pkg::CNT_BITS'(cps_pkg::MAX_TOKENS));
    last_is_set = (token_count != '0) &&
                  ((kind_q[last_idx] == cps_pkg::KIND_SET) ||
                   (kind_q[last_idx] == cps_pkg::KIND_NSET));
    do_append   = accept && (op == cps_pkg::OP_TOKEN) && !full;
    do_member   = accept && (op == cps_pkg::OP_MEMBER) && last_is_set;
  end

  // Load status
  always_comb begin
    case (op)
      cps_pkg::OP_TOKEN:  status = full ? cps_pkg::ST_FULL : cps_pkg::ST_OK;
      cps_pkg::OP_MEMBER: status = last_is_set ? cps_pkg::ST_OK : cps_pkg::ST_NO_SET;
      default:            status = cps_pkg::ST_OK;
    endcase
  end

  // Token count
  always_ff @(posedge clk) begin
    if (rst) begin
      token_count <= '0;
    end else if (do_append) begin
      token_count <= token_count + 1'b1;
    end
  end

  // Token tables; a new token starts with an empty set
  always_ff @(posedge clk) begin
    if (do_append) begin
      kind_q[token_count[cps_pkg::IDX_BITS-1:0]]  <= token_kind;
      byte_q[token_count[cps_pkg::IDX_BITS-1:0]]  <= byte_value;
      set_map[token_count[cps_pkg::IDX_BITS-1:0]] <= '0;
    end
    if (do_member) begin
      set_map[last_idx][byte_value] <= 1'b1;
    end
  end

  // Per-token compare lanes
  always_comb begin
    pat.count = token_count;
    for (int i = 0; i < cps_pkg::MAX_TOKENS; i++) begin
      case (kind_q[i])
        cps_pkg::KIND_LITERAL: pat.hits[i] = (byte_q[i] == byte_value);
        cps_pkg::KIND_ANY:     pat.hits[i] = 1'b1;
        cps_pkg::KIND_SET:     pat.hits[i] = set_map[i][byte_value];
        cps_pkg::KIND_NSET:    pat.hits[i] = !set_map[i][byte_value];
        cps_pkg::KIND_LOWER:   pat.hits[i] = (byte_value >= cps_pkg::CH_LOWER_A) &&
                                             (byte_value <= cps_pkg::CH_LOWER_Z);
        cps_pkg::KIND_UPPER:   pat.hits[i] = (byte_value >= cps_pkg::CH_UPPER_A) &&
                                             (byte_value <= cps_pkg::CH_UPPER_Z);
        default:               pat.hits[i] = 1'b0;
      endcase
    end
  end

endmodule

// ===== rtl/core/cps_search.sv =====
// ----------------------------------------------------------------------------
// cps_search
// Shift-and prefix register, text position and first-match latch.
// ----------------------------------------------------------------------------
module cps_search (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    op,
  input  logic          last_byte,
  input  cps_pkg::pat_t pat,
  output cps_pkg::res_t res
);

  logic [cps_pkg::MAX_TOKENS-1:0] prefixes, prefixes_next;
  logic [cps_pkg::MAX_TOKENS-1:0] limit;
  logic [cps_pkg::POS_BITS-1:0]   text_position, text_position_next;
  logic [cps_pkg::POS_BITS-1:0]   first_start, first_start_next;
  logic                           match_seen, match_seen_next;
  logic [cps_pkg::IDX_BITS-1:0]   top_idx;
  logic [32:0]                    start_wide;
  logic                           clear;

  // Tokens in use
  always_comb begin
    for (int i = 0; i < cps_pkg::MAX_TOKENS; i++) begin
      limit[i] = (cps_pkg::CNT_BITS'(i) < pat.count);
    end
    top_idx = cps_pkg::IDX_BITS'(pat.count - 1'b1);
  end

  // Next search state and the item's result
  always_comb begin
    prefixes_next      = prefixes;
    text_position_next = text_position;
    match_seen_next    = match_seen;
    first_start_next   = first_start;
    res.done           = 1'b0;
    clear              = 1'b0;
    if (op == cps_pkg::OP_TEXT) begin
      if (pat.count != '0) begin
        prefixes_next = {prefixes[cps_pkg::MAX_TOKENS-2:0], 1'b1} & pat.hits & limit;
        if (!match_seen && prefixes_next[top_idx]) begin
          match_seen_next = 1'b1;
          if (&text_position) begin
            first_start_next = text_position;
          end else begin
            first_start_next = text_position -
                               cps_pkg::POS_BITS'(pat.count - 1'b1);
          end
        end
      end
      if (!(&text_position)) begin
        text_position_next = text_position + 1'b1;
      end
      res.done = last_byte;
      clear    = last_byte;
    end else if (op == cps_pkg::OP_RESTART) begin
      prefixes_next      = '0;
      text_position_next = '0;
      match_seen_next    = 1'b0;
      first_start_next   = '0;
    end
    // Reported start, limited to the output field
    start_wide = match_seen_next ? 33'(first_start_next) : 33'd0;
    if (start_wide > 33'((1 << cps_pkg::START_BITS) - 1)) begin
      start_wide = 33'((1 << cps_pkg::START_BITS) - 1);
    end
    res.found = match_seen_next;
    res.start = start_wide[cps_pkg::START_BITS-1:0];
  end

  // Search state; end of text clears it after reporting
  always_ff @(posedge clk) begin
    if (rst) begin
      prefixes      <= '0;
      text_position <= '0;
      match_seen    <= 1'b0;
      first_start   <= '0;
    end else if (accept) begin
      if (clear) begin
        prefixes      <= '0;
        text_position <= '0;
        match_seen    <= 1'b0;
        first_start   <= '0;
      end else begin
        prefixes      <= prefixes_next;
        text_position <= text_position_next;
        match_seen    <= match_seen_next;
        first_start   <= first_start_next;
      end
    end
  end

  // End of text leaves a clean search state
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == cps_pkg::OP_TEXT) && last_byte) |=>
    ((text_position == '0) && !match_seen && (prefixes == '0)))
    else $error("search state not cleared after end of text");

  // First start holds once latched within a text
  a_first_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && match_seen && (op != cps_pkg::OP_RESTART) &&
     !((op == cps_pkg::OP_TEXT) && last_byte)) |=>
    (match_seen && (first_start == $past(first_start))))
    else $error("first match start changed");

  // Prefix bits stay within the loaded tokens
  a_prefix_limit: assert property (@(posedge clk) disable iff (rst)
    ((prefixes & ~limit) == '0))
    else $error("prefix bit beyond token count");

endmodule

// ===== rtl/core/cps_out.sv =====
// ----------------------------------------------------------------------------
// cps_out
// Result register between the search logic and the output channel.
// ----------------------------------------------------------------------------
module cps_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  cps_pkg::res_t res,
  input  logic [1:0]    res_status,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          found,
  output logic [15:0]   match_start,
  output logic          done_res,
  output logic [1:0]    status
);

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      found       <= res.found;
      match_start <= res.start;
      done_res    <= res.done;
      status      <= res_status;
    end
  end

  // A load status never comes with end of text
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != cps_pkg::ST_OK)) |-> !done_res)
    else $error("status and done both set");

  // No start reported without a match
  a_start_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_start == '0))
    else $error("start reported without match");

  // A held result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/class_pattern_text_search.sv =====
// ----------------------------------------------------------------------------
// class_pattern_text_search
// Pattern search with character classes over a byte stream (shift-and).
// ----------------------------------------------------------------------------
// An accepted item's result is held in the output register from the next cycle.
// Throughput: one item per cycle while in_stall is low; the single result register limits it.
// in_stall rises only while a result is held by out_stall.
// Reset: synchronous; clears token count, search state and output valid.
// Token tables and sets are not cleared; a set is emptied when its token loads.
module class_pattern_text_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  token_kind,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [15:0] match_start,
  output logic        done_res,
  output logic [1:0]  status
);

  cps_pkg::pat_t pat;
  cps_pkg::res_t res;
  logic [1:0]    load_status;
  logic          accept;

  // Input handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  cps_pattern u_pattern (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .token_kind (token_kind),
    .byte_value (byte_value),
    .pat        (pat),
    .status     (load_status)
  );

  cps_search u_search (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .last_byte (last_byte),
    .pat       (pat),
    .res       (res)
  );

  cps_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .res         (res),
    .res_status  (load_status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .found       (found),
    .match_start (match_start),
    .done_res    (done_res),
    .status      (status)
  );

endmodule
